### hdl/bcp_pkg.sv
`default_nettype none
package bcp_pkg;

    // Corner coordinate in half-millimetres: 2*centre +/- size.
    localparam int PW    = 21;
    // Coefficient width, signed Q16.16.
    localparam int CW    = 32;
    // Product width and accumulated row sum width.
    localparam int MW    = CW + PW;
    localparam int SW    = 56;
    // Quotient bits below the saturation limit.
    localparam int QW    = 15;
    localparam int NREG  = 6;
    localparam int CFGW  = 64;

    typedef logic signed [PW-1:0] t_pt;
    typedef logic signed [MW-1:0] t_prod;
    typedef logic signed [SW-1:0] t_sum;

    // One quotient lane in the divider pipeline.
    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [SW-1:0] rem;
        logic [QW-1:0] quo;
    } t_lane;

    // Control that travels with each corner.
    typedef struct packed {
        logic [1:0] idx;
        logic       last;
    } t_tag;

endpackage
`default_nettype wire

### hdl/box_corner_projector.sv
`default_nettype none
// Box corner projector. Each transaction on the slave side carries one box
// (signed centre and unsigned size in millimetres); the block produces four
// transactions on the master side, one projected corner each, in order 0..3,
// with tlast on the fourth. A corner is formed in half-millimetres, multiplied
// by the 3x4 projection matrix held in six 64-bit registers (two signed Q16.16
// coefficients each, lower column in the low word), and u = X/Z, v = Y/Z are
// truncated toward zero and saturated to 16 bits. When Z <= 0 the corner is
// flagged behind_camera and both pixels are zero. The block emits one corner
// per cycle unless the master side stalls; the slave side is ready again in
// the cycle the fourth corner of the current box enters the pipeline. The pipeline
// is 21 register stages deep: corner forming, nine parallel multipliers, two
// adder levels, magnitude and saturation check, fifteen restoring divider
// stages (one quotient bit each for X and Y), and the output register. A stall
// on the master side holds every stage in place. Configuration writes are
// applied at once; the registers must only be written while the block is idle.
module box_corner_projector (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [63:0]   i_cfg_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // center_x[18:0], center_y[37:19], center_z[56:38], size_x[72:57],
    // size_y[88:73], size_z[104:89], zero fill up to bit 111
    input  wire logic [111:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // pixel_u[15:0], pixel_v[31:16], behind_camera[32], zero fill to bit 39
    output logic [39:0]        m_axis_tdata,
    // corner_index[1:0]
    output logic [1:0]         m_axis_tuser,
    output logic               m_axis_tlast
);

    localparam int NDIV = bcp_pkg::QW;

    // Projection matrix registers.
    logic [bcp_pkg::CFGW-1:0] r_mat [bcp_pkg::NREG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bcp_pkg::NREG; i++) r_mat[i] <= '0;
        end else if (i_cfg_we && (i_cfg_index < 3'(bcp_pkg::NREG))) begin
            r_mat[i_cfg_index] <= i_cfg_data;
        end
    end

    function automatic logic signed [bcp_pkg::CW-1:0] coef(input int row, input int col);
        logic [bcp_pkg::CFGW-1:0] w;
        w = r_mat[row*2 + col/2];
        return (col % 2 == 1) ? w[63:32] : w[31:0];
    endfunction

    // The whole pipeline moves together unless the output holds a corner
    // that has not been taken.
    logic w_adv;
    logic r_ov;
    assign w_adv = !r_ov || m_axis_tready;

    // Sequencer: holds the current box and steps through its corners.
    logic                    r_busy;
    logic [1:0]              r_k;
    logic signed [18:0]      r_c [3];
    logic [15:0]             r_s [3];
    logic                    w_acc;

    assign s_axis_tready = w_adv && (!r_busy || r_k == 2'd3);
    assign w_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 2'd0;
        end else if (w_adv) begin
            if (w_acc) begin
                r_busy <= 1'b1;
                r_k    <= 2'd0;
            end else if (r_busy) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_c[0] <= s_axis_tdata[18:0];
            r_c[1] <= s_axis_tdata[37:19];
            r_c[2] <= s_axis_tdata[56:38];
            r_s[0] <= s_axis_tdata[72:57];
            r_s[1] <= s_axis_tdata[88:73];
            r_s[2] <= s_axis_tdata[104:89];
        end
    end

    // Corner signs: x is plus on corners 1 and 2, z on corners 2 and 3, and
    // y is the opposite of x for a box at or above zero, equal to x below.
    logic [2:0] w_plus;
    always_comb begin
        w_plus[0] = (r_k == 2'd1) || (r_k == 2'd2);
        w_plus[2] = r_k[1];
        w_plus[1] = r_c[1][18] ? w_plus[0] : !w_plus[0];
    end

    // Stage 1: corner point.
    logic           r_v1;
    bcp_pkg::t_tag  r_t1;
    bcp_pkg::t_pt   r_p [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_adv) r_v1 <= r_busy;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t1.idx  <= r_k;
            r_t1.last <= (r_k == 2'd3);
            for (int a = 0; a < 3; a++) begin
                if (w_plus[a])
                    r_p[a] <= {{1{r_c[a][18]}}, r_c[a], 1'b0} + {5'd0, r_s[a]};
                else
                    r_p[a] <= {{1{r_c[a][18]}}, r_c[a], 1'b0} - {5'd0, r_s[a]};
            end
        end
    end

    // Stage 2: nine products and the translation column.
    logic                             r_v2;
    bcp_pkg::t_tag                    r_t2;
    bcp_pkg::t_prod                   r_m [3][3];
    logic signed [bcp_pkg::CW-1:0]    r_tr [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (w_adv) r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t2 <= r_t1;
            for (int r = 0; r < 3; r++) begin
                r_tr[r] <= coef(r, 3);
                for (int c = 0; c < 3; c++) r_m[r][c] <= coef(r, c) * r_p[c];
            end
        end
    end

    // Stage 3: pairwise sums.
    logic           r_v3;
    bcp_pkg::t_tag  r_t3;
    bcp_pkg::t_sum  r_ha [3];
    bcp_pkg::t_sum  r_hb [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (w_adv) r_v3 <= r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t3 <= r_t2;
            for (int r = 0; r < 3; r++) begin
                r_ha[r] <= bcp_pkg::SW'(r_m[r][0]) + bcp_pkg::SW'(r_m[r][1]);
                r_hb[r] <= bcp_pkg::SW'(r_m[r][2]) + bcp_pkg::SW'(r_tr[r]);
            end
        end
    end

    // Stage 4: X, Y, Z.
    logic           r_v4;
    bcp_pkg::t_tag  r_t4;
    bcp_pkg::t_sum  r_xyz [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (w_adv) r_v4 <= r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t4 <= r_t3;
            for (int r = 0; r < 3; r++) r_xyz[r] <= r_ha[r] + r_hb[r];
        end
    end

    // Stage 5: magnitudes, depth check and saturation check.
    logic                     r_v5;
    bcp_pkg::t_tag            r_t5;
    logic                     r_beh5;
    logic [bcp_pkg::SW-1:0]   r_z5;
    bcp_pkg::t_lane           r_l5 [2];
    logic [bcp_pkg::SW-1:0]   w_mag [2];
    logic [bcp_pkg::SW+bcp_pkg::QW-1:0] w_zlim;

    always_comb begin
        for (int i = 0; i < 2; i++)
            w_mag[i] = r_xyz[i][bcp_pkg::SW-1] ? (bcp_pkg::SW)'(-r_xyz[i])
                                               : (bcp_pkg::SW)'(r_xyz[i]);
        w_zlim = {r_xyz[2], {bcp_pkg::QW{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else if (w_adv) r_v5 <= r_v4;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t5   <= r_t4;
            r_beh5 <= r_xyz[2][bcp_pkg::SW-1] || (r_xyz[2] == '0);
            r_z5   <= r_xyz[2];
            for (int i = 0; i < 2; i++) begin
                r_l5[i].neg <= r_xyz[i][bcp_pkg::SW-1];
                r_l5[i].ovf <= {{bcp_pkg::QW{1'b0}}, w_mag[i]} >= w_zlim;
                r_l5[i].rem <= w_mag[i];
                r_l5[i].quo <= '0;
            end
        end
    end

    // Divider: one restoring step per stage, most significant bit first.
    logic                     r_dv   [NDIV];
    bcp_pkg::t_tag            r_dt   [NDIV];
    logic                     r_dbeh [NDIV];
    logic [bcp_pkg::SW-1:0]   r_dz   [NDIV];
    bcp_pkg::t_lane           r_dl   [NDIV][2];

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        localparam int BIT = NDIV - 1 - g;
        logic                     w_v;
        bcp_pkg::t_tag            w_t;
        logic                     w_beh;
        logic [bcp_pkg::SW-1:0]   w_z;
        bcp_pkg::t_lane           w_l [2];
        bcp_pkg::t_lane           n_l [2];
        logic [bcp_pkg::SW+bcp_pkg::QW-1:0] w_sh;

        if (g == 0) begin : g_first
            assign w_v   = r_v5;
            assign w_t   = r_t5;
            assign w_beh = r_beh5;
            assign w_z   = r_z5;
            assign w_l   = r_l5;
        end else begin : g_next
            assign w_v   = r_dv[g-1];
            assign w_t   = r_dt[g-1];
            assign w_beh = r_dbeh[g-1];
            assign w_z   = r_dz[g-1];
            assign w_l   = r_dl[g-1];
        end

        assign w_sh = {{bcp_pkg::QW{1'b0}}, w_z} << BIT;

        always_comb begin
            for (int i = 0; i < 2; i++) begin
                n_l[i] = w_l[i];
                if ({{bcp_pkg::QW{1'b0}}, w_l[i].rem} >= w_sh) begin
                    n_l[i].rem      = w_l[i].rem - w_sh[bcp_pkg::SW-1:0];
                    n_l[i].quo[BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[g] <= 1'b0;
            else if (w_adv) r_dv[g] <= w_v;
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dt[g]   <= w_t;
                r_dbeh[g] <= w_beh;
                r_dz[g]   <= w_z;
                r_dl[g]   <= n_l;
            end
        end
    end

    // Output register: sign, saturation and the behind-camera override.
    logic [15:0]    w_pix [2];
    logic [15:0]    r_pix [2];
    logic           r_beh;
    bcp_pkg::t_tag  r_to;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            if (r_dbeh[NDIV-1])
                w_pix[i] = '0;
            else if (r_dl[NDIV-1][i].ovf)
                w_pix[i] = r_dl[NDIV-1][i].neg ? 16'h8000 : 16'h7FFF;
            else if (r_dl[NDIV-1][i].neg)
                w_pix[i] = 16'(-{1'b0, r_dl[NDIV-1][i].quo});
            else
                w_pix[i] = {1'b0, r_dl[NDIV-1][i].quo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_adv) r_ov <= r_dv[NDIV-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pix <= w_pix;
            r_beh <= r_dbeh[NDIV-1];
            r_to  <= r_dt[NDIV-1];
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_beh, r_pix[1], r_pix[0]};
    assign m_axis_tuser  = r_to.idx;
    assign m_axis_tlast  = r_to.last;

    // A corner behind the camera never carries pixel values.
    a_beh_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_beh |-> (r_pix[0] == '0) && (r_pix[1] == '0))
        else $error("behind-camera corner with nonzero pixels");

    // The frame marker sits only on the fourth corner.
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_to.last == (r_to.idx == 2'd3)))
        else $error("tlast does not match corner index");

    // A new box starts at corner zero.
    a_acc_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_busy && (r_k == 2'd0))
        else $error("accepted box does not start at corner zero");

    // While a box is in progress, the slave side is only ready on its last corner.
    a_rdy_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && r_busy |-> (r_k == 2'd3))
        else $error("box accepted before the previous one finished");

endmodule
`default_nettype wire
